>>> hw/rtl/cartridge_bank_mapper_core_assert.svh
// Assertion macros for the cartridge bank mapper checker.
`ifndef CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH
`define CARTRIDGE_BANK_MAPPER_CORE_ASSERT_SVH

// same-cycle implication
`define CBM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CBM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/cbm_pkg.sv
`default_nettype none

package cbm_pkg;

  localparam int SOUND_RAM_DEPTH = 128;
  localparam int SND_AW          = $clog2(SOUND_RAM_DEPTH);
  localparam int PATTERN_SLOTS   = 12;
  localparam int PRG_SLOTS       = 3;

  typedef enum logic [1:0] {
    MODE_PRG_RD,
    MODE_PRG_WR,
    MODE_CHR_RD,
    MODE_CHR_WR
  } mode_e;

  typedef enum logic [2:0] {
    TGT_NONE,
    TGT_INTERNAL,
    TGT_PRG_ROM,
    TGT_WORK_RAM,
    TGT_CHR_ROM,
    TGT_CHR_RAM,
    TGT_NAMETABLE
  } target_e;

  typedef enum logic [1:0] {
    REV_129,
    REV_163,
    REV_175,
    REV_340
  } rev_e;

  // config register indexes
  localparam logic CFG_REVISION = 1'b0;
  localparam logic CFG_CHR_RAM  = 1'b1;

  // nametable mirroring modes
  localparam logic [1:0] MIR_SINGLE0 = 2'd0;
  localparam logic [1:0] MIR_VERT    = 2'd1;
  localparam logic [1:0] MIR_HORZ    = 2'd2;
  localparam logic [1:0] MIR_SINGLE1 = 2'd3;

  // address[15:11] decode of CPU register windows
  localparam logic [4:0] SEL_SND      = 5'h09;
  localparam logic [4:0] SEL_IRQ_LO   = 5'h0a;
  localparam logic [4:0] SEL_IRQ_HI   = 5'h0b;
  localparam logic [4:0] SEL_CHR_NT0  = 5'h18;
  localparam logic [4:0] SEL_PRG0     = 5'h1c;
  localparam logic [4:0] SEL_PRG1     = 5'h1d;
  localparam logic [4:0] SEL_PRG2     = 5'h1e;
  localparam logic [4:0] SEL_SND_ADDR = 5'h1f;

  localparam logic [5:0] PRG_LAST_BANK = 6'h3f;
  localparam logic [7:0] RAM_BANK_MIN  = 8'he0;

  typedef struct packed {
    mode_e       mode;
    logic [15:0] address;
    logic [7:0]  write_data;
  } item_t;

  typedef struct packed {
    target_e     target;
    logic [18:0] ext_addr;
    logic [7:0]  read_data;
    logic        ext_write;
    logic        irq_clear;
  } result_t;

  typedef struct packed {
    logic [PRG_SLOTS-1:0][5:0]     program_banks;
    logic [PATTERN_SLOTS-1:0][7:0] pattern_banks;
    logic [14:0]                   irq_count;
    logic                          irq_enabled;
    logic [1:0]                    pattern_ram_off;
    logic                          sound_off;
    logic [SND_AW-1:0]             sound_pointer;
    logic                          sound_autoinc;
    logic                          work_ram_on;
    logic [1:0]                    mirroring;
  } regs_t;

  typedef struct packed {
    logic              we;
    logic [SND_AW-1:0] addr;
    logic [7:0]        data;
  } snd_wr_t;

  function automatic logic has_sound(input rev_e rev);
    return (rev == REV_129) || (rev == REV_163);
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/cbm_snd_ram.sv
`default_nettype none

module cbm_snd_ram
  import cbm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire snd_wr_t           wr,
  input  wire logic [SND_AW-1:0] rd_addr,
  output logic [7:0]             rd_data
);

  logic [7:0]                 mem [SOUND_RAM_DEPTH];
  logic [SOUND_RAM_DEPTH-1:0] valid;
  logic [7:0]                 rd_q;
  logic                       vld_q;

  // read follows the pointer value the next item will see; same-cycle write bypassed
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (wr.we && (wr.addr == rd_addr)) begin
      rd_q <= wr.data;
    end else begin
      rd_q <= mem[rd_addr];
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      vld_q <= 1'b0;
    end else begin
      if (wr.we) begin
        valid[wr.addr] <= 1'b1;
      end
      vld_q <= (wr.we && (wr.addr == rd_addr)) || valid[rd_addr];
    end
  end

  assign rd_data = vld_q ? rd_q : 8'h00;

endmodule

`default_nettype wire

>>> hw/rtl/cbm_decode.sv
`default_nettype none

module cbm_decode
  import cbm_pkg::*;
(
  input  wire item_t      item,
  input  wire regs_t      regs,
  input  wire rev_e       revision,
  input  wire logic       chr_ram_present,
  input  wire logic [7:0] snd_rd_data,
  output result_t         res,
  output regs_t           regs_next,
  output snd_wr_t         snd_wr
);

  logic [15:0]       a;
  logic [7:0]        d;
  logic [4:0]        sel;
  logic              snd;
  logic [SND_AW-1:0] ptr_inc;
  logic [13:0]       p;
  logic [13:0]       pm;
  logic [7:0]        bank;
  logic              ram_ok;
  logic [17:0]       t;
  logic [10:0]       nt_addr;
  logic              writing;
  logic              nt_direct;

  assign a       = item.address;
  assign d       = item.write_data;
  assign sel     = a[15:11];
  assign snd     = has_sound(revision);
  assign ptr_inc = regs.sound_pointer + 1'b1;

  // pattern side
  assign p         = a[13:0];
  assign nt_direct = p[13] && ((revision == REV_175) || (revision == REV_340));
  assign pm        = p[13] ? {p[13], 1'b0, p[11:0]} : p;
  assign bank      = regs.pattern_banks[pm[13:10]];
  assign ram_ok    = pm[13] || !regs.pattern_ram_off[pm[12]];
  assign t         = {bank, pm[9:0]};
  assign writing   = (item.mode == MODE_CHR_WR);

  always_comb begin
    unique case (regs.mirroring)
      MIR_SINGLE0: nt_addr = {1'b0, p[9:0]};
      MIR_VERT:    nt_addr = {p[10], p[9:0]};
      MIR_HORZ:    nt_addr = {p[11], p[9:0]};
      MIR_SINGLE1: nt_addr = {1'b1, p[9:0]};
      default:     nt_addr = {1'b0, p[9:0]};
    endcase
  end

  always_comb begin
    res        = '0;
    res.target = TGT_NONE;
    regs_next  = regs;
    snd_wr.we   = 1'b0;
    snd_wr.addr = regs.sound_pointer;
    snd_wr.data = d;

    unique case (item.mode)
      MODE_PRG_RD: begin
        if (sel == SEL_SND) begin
          if (snd) begin
            res.target    = TGT_INTERNAL;
            res.read_data = snd_rd_data;
            if (regs.sound_autoinc) begin
              regs_next.sound_pointer = ptr_inc;
            end
          end
        end else if (sel == SEL_IRQ_LO) begin
          res.target    = TGT_INTERNAL;
          res.read_data = regs.irq_count[7:0];
        end else if (sel == SEL_IRQ_HI) begin
          res.target    = TGT_INTERNAL;
          res.read_data = {regs.irq_enabled, regs.irq_count[14:8]};
        end else if (a[15:13] == 3'b011) begin
          if (regs.work_ram_on) begin
            res.target   = TGT_WORK_RAM;
            res.ext_addr = {6'd0, a[12:0]};
          end
        end else if (a[15:13] == 3'b111) begin
          res.target   = TGT_PRG_ROM;
          res.ext_addr = {PRG_LAST_BANK, a[12:0]};
        end else if (a[15]) begin
          res.target   = TGT_PRG_ROM;
          res.ext_addr = {regs.program_banks[a[14:13]], a[12:0]};
        end
      end

      MODE_PRG_WR: begin
        if (a[15:13] == 3'b011) begin
          if (regs.work_ram_on) begin
            res.target    = TGT_WORK_RAM;
            res.ext_addr  = {6'd0, a[12:0]};
            res.ext_write = 1'b1;
          end
        end else if (a[15:14] == 2'b10) begin
          regs_next.pattern_banks[{1'b0, a[13:11]}] = d;
        end else if (a[15:13] == 3'b110) begin
          if ((sel == SEL_CHR_NT0) && (revision == REV_175)) begin
            regs_next.work_ram_on = d[0];
          end
          if (snd) begin
            regs_next.pattern_banks[4'd8 + {2'b00, a[12:11]}] = d;
          end
        end else begin
          case (sel)
            SEL_SND: begin
              if (snd) begin
                snd_wr.we = 1'b1;
                if (regs.sound_autoinc) begin
                  regs_next.sound_pointer = ptr_inc;
                end
              end
            end
            SEL_IRQ_LO: begin
              if (snd) begin
                regs_next.irq_count[7:0] = d;
                res.irq_clear = 1'b1;
              end
            end
            SEL_IRQ_HI: begin
              if (snd) begin
                regs_next.irq_count[14:8] = d[6:0];
                regs_next.irq_enabled     = d[7];
                res.irq_clear = 1'b1;
              end
            end
            SEL_PRG0: begin
              regs_next.program_banks[0] = d[5:0];
              if (snd) begin
                regs_next.sound_off = d[6];
              end else if (revision == REV_340) begin
                regs_next.mirroring = d[7:6];
              end
            end
            SEL_PRG1: begin
              regs_next.program_banks[1] = d[5:0];
              if (snd) begin
                regs_next.pattern_ram_off = d[7:6];
              end
            end
            SEL_PRG2: begin
              regs_next.program_banks[2] = d[5:0];
            end
            SEL_SND_ADDR: begin
              if (snd) begin
                regs_next.sound_pointer = d[SND_AW-1:0];
                regs_next.sound_autoinc = d[7];
              end
            end
            default: begin
            end
          endcase
        end
      end

      MODE_CHR_RD, MODE_CHR_WR: begin
        if (nt_direct) begin
          res.target    = TGT_NAMETABLE;
          res.ext_addr  = {8'd0, nt_addr};
          res.ext_write = writing;
        end else if ((bank >= RAM_BANK_MIN) && ram_ok) begin
          if (chr_ram_present) begin
            res.target   = TGT_CHR_RAM;
            res.ext_addr = {1'b0, t};
          end else begin
            res.target   = TGT_NAMETABLE;
            res.ext_addr = {8'd0, t[10:0]};
          end
          res.ext_write = writing;
        end else if (!writing) begin
          res.target   = TGT_CHR_ROM;
          res.ext_addr = {1'b0, t};
        end
      end

      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/cbm_state.sv
`default_nettype none

module cbm_state
  import cbm_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [1:0] cfg_data,
  input  wire logic       update,
  input  wire regs_t      regs_next,
  output regs_t           regs,
  output rev_e            revision,
  output logic            chr_ram_present
);

  regs_t regs_init;

  // power-on state for the default revision
  always_comb begin
    regs_init             = '0;
    regs_init.sound_off   = 1'b1;
    regs_init.work_ram_on = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      regs            <= regs_init;
      revision        <= REV_163;
      chr_ram_present <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_REVISION: begin
          revision         <= rev_e'(cfg_data);
          regs.work_ram_on <= (cfg_data != REV_175);
        end
        CFG_CHR_RAM: chr_ram_present <= cfg_data[0];
        default: begin
        end
      endcase
    end else if (update) begin
      regs <= regs_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/cartridge_bank_mapper_core.sv
// Channel   Dir  Fields (tdata / tuser, from bit 0 up)
// s_*       in   tdata: address[15:0], write_data[23:16]; tuser: mode[1:0]
// m_*       out  tdata: external_address[18:0], read_data[26:19], external_write[27],
//                       irq_clear[28], zero[31:29]; tuser: target[2:0]
// cfg_*     in   cfg_index 0 revision, 1 chr_ram_present; cfg_data[1:0]
//
// Each item is held in the input register and then in the result register.
// Throughput: one item per cycle while m_tready does not stall; bank, IRQ and sound RAM
// state update as an item leaves the input register, so the next item sees it.
// Sound RAM: 128 x 8 memory with registered read, tracking the sound pointer.
// Reset restores the power-on control state (sound off, work RAM on, revision 163) and
// marks all sound RAM bytes as zero at once. A low m_tready stalls the result register;
// the input register then fills and s_tready drops.
`default_nettype none

module cartridge_bank_mapper_core
  import cbm_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [23:0] s_tdata,   // address, write_data
  input  wire logic [1:0]  s_tuser,   // mode
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [31:0]      m_tdata,   // external_address, read_data, external_write, irq_clear
  output logic [2:0]       m_tuser,   // target
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [1:0]  cfg_data
);

  item_t             s_item;
  item_t             s1_item;
  logic              s1_valid;
  logic              advance;
  result_t           res;
  result_t           out_res;
  regs_t             regs;
  regs_t             regs_next;
  rev_e              revision;
  logic              chr_ram_present;
  snd_wr_t           snd_wr;
  snd_wr_t           snd_wr_g;
  logic [SND_AW-1:0] snd_rd_addr;
  logic [7:0]        snd_rd_data;

  assign s_item.mode       = mode_e'(s_tuser);
  assign s_item.address    = s_tdata[15:0];
  assign s_item.write_data = s_tdata[23:16];

  assign advance  = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        s1_valid <= 1'b1;
      end else if (advance) begin
        s1_valid <= 1'b0;
      end
      if (advance) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_item <= s_item;
    end
    if (advance) begin
      out_res <= res;
    end
  end

  cbm_decode u_decode (
    .item            (s1_item),
    .regs            (regs),
    .revision        (revision),
    .chr_ram_present (chr_ram_present),
    .snd_rd_data     (snd_rd_data),
    .res             (res),
    .regs_next       (regs_next),
    .snd_wr          (snd_wr)
  );

  cbm_state u_state (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .update          (advance),
    .regs_next       (regs_next),
    .regs            (regs),
    .revision        (revision),
    .chr_ram_present (chr_ram_present)
  );

  assign snd_wr_g.we   = snd_wr.we && advance;
  assign snd_wr_g.addr = snd_wr.addr;
  assign snd_wr_g.data = snd_wr.data;
  assign snd_rd_addr   = advance ? regs_next.sound_pointer : regs.sound_pointer;

  cbm_snd_ram u_snd_ram (
    .clk     (clk),
    .rst     (rst),
    .wr      (snd_wr_g),
    .rd_addr (snd_rd_addr),
    .rd_data (snd_rd_data)
  );

  assign m_tdata = {3'b000, out_res.irq_clear, out_res.ext_write, out_res.read_data,
                    out_res.ext_addr};
  assign m_tuser = out_res.target;

endmodule

`default_nettype wire

>>> hw/rtl/cbm_checker.sv
`default_nettype none
`include "cartridge_bank_mapper_core_assert.svh"

module cbm_checker
  import cbm_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [31:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  `CBM_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser), "result changed while stalled")

  `CBM_ASSERT_IMP(a_none_zero, clk, rst, m_tvalid && (m_tuser == TGT_NONE), m_tdata[26:0] == 27'd0, "open bus item carries address or data")

  `CBM_ASSERT_IMP(a_write_target, clk, rst, m_tvalid && m_tdata[27], (m_tuser == TGT_WORK_RAM) || (m_tuser == TGT_CHR_RAM) || (m_tuser == TGT_NAMETABLE), "write strobe to a read-only target")

  `CBM_ASSERT_IMP(a_irq_clear, clk, rst, m_tvalid && m_tdata[28], (m_tuser == TGT_NONE) && !m_tdata[27], "IRQ acknowledge on a memory access")

  `CBM_ASSERT_IMP(a_nt_range, clk, rst, m_tvalid && (m_tuser == TGT_NAMETABLE), m_tdata[18:11] == 8'd0, "nametable address beyond 2 KiB")

endmodule

bind cartridge_bank_mapper_core cbm_checker u_cbm_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire
